// ===== sv/assert_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CRT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("call/return tracker check failed");

// antecedent implies consequent in the next cycle
`define CRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("call/return tracker check failed");

`endif

// ===== sv/crt_pkg.sv =====
// types, constants and decode functions of the call/return tracker
`timescale 1ns / 1ps
`default_nettype none

package crt_pkg;

  // instruction fields
  localparam logic [6:0] OPC_JAL  = 7'h6f;
  localparam logic [6:0] OPC_JALR = 7'h67;
  localparam logic [2:0] F3_JALR  = 3'h0;
  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;
  localparam logic [4:0] REG_T0   = 5'd5;

  // event kinds
  localparam logic EV_CALL = 1'b0;
  localparam logic EV_RET  = 1'b1;

  localparam int DEPTH_W = 7;

  typedef struct packed {
    logic [63:0] pc_now;
    logic [31:0] instr_word;
    logic [63:0] pc_next;
  } in_word_t;

  typedef struct packed {
    logic               event_kind;
    logic [63:0]        event_pc;
    logic [63:0]        jump_target;
    logic [63:0]        callee_address;
    logic [63:0]        caller_site;
    logic [DEPTH_W-1:0] depth_after;
    logic               unmatched_flag;
    logic               overflow_flag;
  } out_word_t;

  // one stack frame
  typedef struct packed {
    logic [63:0] callee;
    logic [63:0] call_site;
  } frame_t;

  // shift control broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  function automatic logic is_link(input logic [4:0] r);
    is_link = (r == REG_RA) || (r == REG_T0);
  endfunction

  // jalr x0, 0(x1)
  function automatic logic is_ret(input logic [31:0] w);
    is_ret = (w[6:0] == OPC_JALR) && (w[14:12] == F3_JALR) &&
             (w[11:7] == REG_ZERO) && (w[19:15] == REG_RA) &&
             (w[31:20] == 12'h000);
  endfunction

  // jal or jalr linking through ra or t0
  function automatic logic is_call(input logic [31:0] w);
    logic jal_call;
    logic jalr_call;
    jal_call  = (w[6:0] == OPC_JAL) && is_link(w[11:7]);
    jalr_call = (w[6:0] == OPC_JALR) && (w[14:12] == F3_JALR) &&
                is_link(w[11:7]) && !is_ret(w);
    is_call   = jal_call || jalr_call;
  endfunction

endpackage

`default_nettype wire

// ===== sv/crt_cell.sv =====
// one frame cell of the shifting call stack
`timescale 1ns / 1ps
`default_nettype none

module crt_cell (
  input  wire logic              clk,
  input  wire crt_pkg::cell_ctl_t ctl,
  input  wire crt_pkg::frame_t    frame_above,
  input  wire crt_pkg::frame_t    frame_below,
  output crt_pkg::frame_t         frame_q
);

  crt_pkg::frame_t frame_r;

  // push takes the frame from above, pop takes it from below
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      frame_r <= frame_above;
    end else if (ctl.pop) begin
      frame_r <= frame_below;
    end
  end

  assign frame_q = frame_r;

endmodule

`default_nettype wire

// ===== sv/riscv_call_return_tracker_core.sv =====
// top level: configuration register, decode, depth counter, frame cell chain and output register
// a call or return word is registered and appears on out_* in the cycle after acceptance
// throughput: one word per cycle while the output is not stalled; every cell shifts
// one place per cycle on a push or pop, so the top frame is ready for the very next word
// reset (synchronous, active low) clears depth, trace_enable and out_valid;
// frame cells are not reset and are only read below the current depth
`timescale 1ns / 1ps
`default_nettype none

module riscv_call_return_tracker_core #(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire crt_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output crt_pkg::out_word_t      out_word,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic               trace_enable_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               out_valid_r;
  crt_pkg::out_word_t out_word_r;
  crt_pkg::out_word_t out_word_nxt;

  logic               accept;
  logic               hit_ret;
  logic               hit_call;
  logic               empty;
  logic               full;
  crt_pkg::cell_ctl_t ctl;
  crt_pkg::frame_t    new_frame;
  crt_pkg::frame_t    frames [STACK_DEPTH];
  logic [CNT_W+crt_pkg::DEPTH_W-1:0] depth_ext;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trace_enable_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      trace_enable_r <= cfg_data;
    end
  end

  // decode and stack control
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign hit_ret  = trace_enable_r && crt_pkg::is_ret(in_word.instr_word);
  assign hit_call = trace_enable_r && crt_pkg::is_call(in_word.instr_word);
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_W'(STACK_DEPTH));
  assign ctl.push = accept && hit_call && !full;
  assign ctl.pop  = accept && hit_ret && !empty;

  assign new_frame.callee    = in_word.pc_next;
  assign new_frame.call_site = in_word.pc_now;

  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.push) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (ctl.pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // frame cell chain, cell 0 holds the top of stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    crt_pkg::frame_t above;
    crt_pkg::frame_t below;
    if (i == 0) begin : g_top
      assign above = new_frame;
    end else begin : g_mid
      assign above = frames[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = frames[i];
    end else begin : g_inner
      assign below = frames[i+1];
    end
    crt_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .frame_above (above),
      .frame_below (below),
      .frame_q     (frames[i])
    );
  end

  // result word
  assign depth_ext = {{crt_pkg::DEPTH_W{1'b0}}, cnt_nxt};

  always_comb begin
    out_word_nxt.event_kind     = hit_ret ? crt_pkg::EV_RET : crt_pkg::EV_CALL;
    out_word_nxt.event_pc       = in_word.pc_now;
    out_word_nxt.jump_target    = in_word.pc_next;
    out_word_nxt.callee_address = in_word.pc_next;
    out_word_nxt.caller_site    = in_word.pc_now;
    out_word_nxt.depth_after    = depth_ext[crt_pkg::DEPTH_W-1:0];
    out_word_nxt.unmatched_flag = hit_ret && empty;
    out_word_nxt.overflow_flag  = !hit_ret && hit_call && full;
    if (hit_ret) begin
      if (empty) begin
        out_word_nxt.callee_address = in_word.pc_now;
      end else begin
        out_word_nxt.callee_address = frames[0].callee;
        out_word_nxt.caller_site    = frames[0].call_site;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && (hit_ret || hit_call)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (hit_ret || hit_call)) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// ===== sv/crt_checker.sv =====
// port-level checker for the call/return tracker and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module crt_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire crt_pkg::out_word_t out_word
);

  logic out_stall;
  logic unmatched_ok;
  logic overflow_ok;

  assign out_stall    = out_valid && !out_ready;
  assign unmatched_ok = (out_word.event_kind == crt_pkg::EV_RET) &&
                        (out_word.depth_after == '0) &&
                        (out_word.callee_address == out_word.event_pc);
  assign overflow_ok  = (out_word.event_kind == crt_pkg::EV_CALL) &&
                        !out_word.unmatched_flag;

  // a stalled result word holds
  `CRT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_word))

  // with the output register empty the block takes a word
  `CRT_ASSERT_IMPL(a_ready_when_free, clk, rst_n, !out_valid, in_ready)

  // an unmatched return leaves an empty stack
  `CRT_ASSERT_IMPL(a_unmatched_ret, clk, rst_n, out_valid && out_word.unmatched_flag, unmatched_ok)

  // overflow only on a call
  `CRT_ASSERT_IMPL(a_overflow_call, clk, rst_n, out_valid && out_word.overflow_flag, overflow_ok)

endmodule

bind riscv_call_return_tracker_core crt_checker u_crt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_word  (out_word)
);

`default_nettype wire
